@@ src/tgr_pkg.sv @@
package tgr_pkg;

  // font geometry
  localparam int GLYPH_COLUMNS = 5;
  localparam int GLYPH_COUNT   = 64;
  localparam int SLOT_W        = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;
  localparam int COL_W         = (GLYPH_COLUMNS > 1) ? $clog2(GLYPH_COLUMNS) : 1;

  // run layout: fixed header, then four bytes per font column
  localparam int HEADER_BEATS = 16;
  localparam int RUN_BEATS    = HEADER_BEATS + 4 * GLYPH_COLUMNS;
  localparam int BEAT_W       = $clog2(RUN_BEATS);

  // field widths
  localparam int COL_POS_W  = 5;
  localparam int ROW_POS_W  = 4;
  localparam int CHAR_W     = 8;
  localparam int BYTE_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int XPIX_W     = 9;

  // job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // reset values
  localparam logic [COL_POS_W-1:0] LINE_START_RST = 5'd7;
  localparam logic [COL_POS_W-1:0] LINE_END_RST   = 5'd19;
  localparam logic [ROW_POS_W-1:0] TOP_ROW_RST    = 4'd7;

  // input codes
  localparam logic             FUNC_HOME  = 1'b1;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;

  // panel commands
  localparam logic [BYTE_W-1:0] CMD_WIN_Y   = 8'h44;
  localparam logic [BYTE_W-1:0] CMD_WIN_X   = 8'h45;
  localparam logic [BYTE_W-1:0] CMD_CNT_Y   = 8'h4E;
  localparam logic [BYTE_W-1:0] CMD_CNT_X   = 8'h4F;
  localparam logic [BYTE_W-1:0] CMD_WRITE   = 8'h24;
  localparam logic [BYTE_W-1:0] BYTE_BLANK  = 8'hFF;
  localparam logic [XPIX_W-1:0] X_END_OFFS  = 9'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_START = 2'd0,
    CFG_LINE_END   = 2'd1,
    CFG_TOP_ROW    = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [COL_POS_W-1:0] x;
    logic [ROW_POS_W-1:0] y;
    logic                 blank;
    logic [SLOT_W-1:0]    slot;
  } job_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_stat_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } slot_t;

  localparam logic [BYTE_W-1:0] FONT [GLYPH_COUNT][GLYPH_COLUMNS] = '{
    '{8'h07,8'hdb,8'hdd,8'hdb,8'h07}, '{8'h7d,8'h01,8'h6d,8'h6d,8'h93},
    '{8'h83,8'h7d,8'h7d,8'h7d,8'hbb}, '{8'h7d,8'h01,8'h7d,8'h7d,8'h83},
    '{8'h01,8'h6d,8'h6d,8'h6d,8'h6d}, '{8'h01,8'hed,8'hed,8'hed,8'hfd},
    '{8'h83,8'h7d,8'h7d,8'h6d,8'h0b}, '{8'h01,8'hef,8'hef,8'hef,8'h01},
    '{8'hff,8'h7d,8'h01,8'h7d,8'hff}, '{8'hbf,8'h7f,8'h7d,8'h81,8'hfd},
    '{8'h01,8'hef,8'hd7,8'hbb,8'h7d}, '{8'h01,8'h7f,8'h7f,8'h7f,8'h7f},
    '{8'h01,8'hfb,8'he7,8'hfb,8'h01}, '{8'h01,8'hf7,8'hef,8'hdf,8'h01},
    '{8'h83,8'h7d,8'h7d,8'h7d,8'h83}, '{8'h01,8'hed,8'hed,8'hed,8'hf3},
    '{8'h83,8'h7d,8'h5d,8'hbd,8'h43}, '{8'h01,8'hed,8'hcd,8'had,8'h73},
    '{8'hb3,8'h6d,8'h6d,8'h6d,8'h9b}, '{8'hfd,8'hfd,8'h01,8'hfd,8'hfd},
    '{8'h81,8'h7f,8'h7f,8'h7f,8'h81}, '{8'hc1,8'hbf,8'h7f,8'hbf,8'hc1},
    '{8'h81,8'h7f,8'h8f,8'h7f,8'h81}, '{8'h39,8'hd7,8'hef,8'hd7,8'h39},
    '{8'hf1,8'hef,8'h1f,8'hef,8'hf1}, '{8'h3d,8'h5d,8'h6d,8'h75,8'h79},
    '{8'hbf,8'h57,8'h57,8'h57,8'h0f}, '{8'h01,8'h6f,8'h77,8'h77,8'h8f},
    '{8'h8f,8'h77,8'h77,8'h77,8'hbf}, '{8'h8f,8'h77,8'h77,8'h6f,8'h01},
    '{8'h8f,8'h57,8'h57,8'h57,8'hcf}, '{8'hef,8'h03,8'hed,8'hfd,8'hfb},
    '{8'hef,8'h57,8'h57,8'h57,8'h87}, '{8'h01,8'hef,8'hf7,8'hf7,8'h0f},
    '{8'hff,8'h6f,8'h05,8'h7f,8'hff}, '{8'hbf,8'h7f,8'h77,8'h85,8'hff},
    '{8'h01,8'hdf,8'haf,8'h77,8'hff}, '{8'hff,8'h7d,8'h01,8'h7f,8'hff},
    '{8'h07,8'hf7,8'h0f,8'hf7,8'h0f}, '{8'h07,8'hef,8'hf7,8'hf7,8'h0f},
    '{8'h8f,8'h77,8'h77,8'h77,8'h8f}, '{8'h07,8'hd7,8'hd7,8'hd7,8'hef},
    '{8'hef,8'hd7,8'hd7,8'hd7,8'h07}, '{8'h07,8'hef,8'hf7,8'hf7,8'hef},
    '{8'h6f,8'h57,8'h57,8'h57,8'hbf}, '{8'hfb,8'h81,8'h7b,8'h7f,8'hbf},
    '{8'h87,8'h7f,8'h7f,8'hbf,8'h07}, '{8'hc7,8'hbf,8'h7f,8'hbf,8'hc7},
    '{8'h87,8'h7f,8'h9f,8'h7f,8'h87}, '{8'h77,8'haf,8'hdf,8'haf,8'h77},
    '{8'he7,8'h5f,8'h5f,8'h5f,8'h87}, '{8'h77,8'h37,8'h57,8'h67,8'h77},
    '{8'h83,8'h5d,8'h6d,8'h75,8'h83}, '{8'hff,8'h7b,8'h01,8'h7f,8'hff},
    '{8'h3b,8'h5d,8'h6d,8'h6d,8'h73}, '{8'hbb,8'h7d,8'h6d,8'h6d,8'h93},
    '{8'hcf,8'hd7,8'hdb,8'h01,8'hdf}, '{8'hb1,8'h75,8'h75,8'h75,8'h8d},
    '{8'h87,8'h6b,8'h6d,8'h6d,8'h9f}, '{8'hfd,8'h1d,8'hed,8'hf5,8'hf9},
    '{8'h93,8'h6d,8'h6d,8'h6d,8'h93}, '{8'hf3,8'h6d,8'h6d,8'had,8'hc3},
    '{8'hff,8'hff,8'hd7,8'hff,8'hff}, '{8'hff,8'hff,8'hff,8'hff,8'hff}
  };

  // ascii code to font slot
  function automatic slot_t glyph_slot(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] s;
    logic              hit;
    slot_t             r;
    s   = '0;
    hit = 1'b0;
    if (ch >= 8'h41 && ch <= 8'h5A) begin
      s   = ch - 8'h41;
      hit = 1'b1;
    end else if (ch >= 8'h61 && ch <= 8'h7A) begin
      s   = ch - 8'h61 + 8'd26;
      hit = 1'b1;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      s   = ch - 8'h30 + 8'd52;
      hit = 1'b1;
    end else if (ch == 8'h3A) begin
      s   = 8'd62;
      hit = 1'b1;
    end else if (ch == 8'h20) begin
      s   = 8'd63;
      hit = 1'b1;
    end
    if (32'(s) >= GLYPH_COUNT) begin
      hit = 1'b0;
    end
    r.hit  = hit;
    r.slot = SLOT_W'(s);
    return r;
  endfunction

  // each nibble bit becomes two adjacent bits
  function automatic logic [BYTE_W-1:0] double_nibble(input logic [3:0] n);
    logic [BYTE_W-1:0] r;
    r = '0;
    for (int i = 0; i < 4; i++) begin
      r[2*i]   = n[i];
      r[2*i+1] = n[i];
    end
    return r;
  endfunction

endpackage

@@ src/tgr_if.sv @@
interface tgr_in_if;
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic [tgr_pkg::CHAR_W-1:0]    char_code;

  modport source (output valid, func, char_code, input ready);
  modport sink   (input valid, func, char_code, output ready);
endinterface

interface tgr_out_if;
  logic                          valid;
  logic                          ready;
  logic                          is_command;
  logic [tgr_pkg::BYTE_W-1:0]    byte_value;
  logic                          last;

  modport source (output valid, is_command, byte_value, last, input ready);
  modport sink   (input valid, is_command, byte_value, last, output ready);
endinterface

interface tgr_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tgr_pkg::CFG_IDX_W-1:0]   index;
  logic [tgr_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/tgr_front.sv @@
module tgr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  tgr_in_if.sink            in_ch,
  tgr_cfg_if.sink           cfg_ch,
  input  tgr_pkg::q_stat_t  q_stat_i,
  output logic              push_o,
  output tgr_pkg::job_t     job_o
);

  logic [tgr_pkg::COL_POS_W-1:0] line_start_q, line_end_q, col_q, col_d;
  logic [tgr_pkg::ROW_POS_W-1:0] top_row_q, row_q, row_d, row_adv;
  logic [tgr_pkg::COL_POS_W:0]   col_inc;
  logic                          wrap, accept, is_nl;
  tgr_pkg::slot_t                slot;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !q_stat_i.full;
  assign accept       = in_ch.valid && in_ch.ready;
  assign is_nl        = in_ch.char_code == tgr_pkg::CH_NEWLINE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_start_q <= tgr_pkg::LINE_START_RST;
      line_end_q   <= tgr_pkg::LINE_END_RST;
      top_row_q    <= tgr_pkg::TOP_ROW_RST;
    end else if (cfg_ch.valid) begin
      case (tgr_pkg::cfg_reg_e'(cfg_ch.index))
        tgr_pkg::CFG_LINE_START: line_start_q <= cfg_ch.data;
        tgr_pkg::CFG_LINE_END:   line_end_q   <= cfg_ch.data;
        tgr_pkg::CFG_TOP_ROW:    top_row_q    <= tgr_pkg::ROW_POS_W'(cfg_ch.data);
        default: ;
      endcase
    end
  end

  // one column step, wrapping to the next row past the line end
  assign col_inc = {1'b0, col_q} + 1'b1;
  assign wrap    = col_inc > {1'b0, line_end_q};
  assign row_adv = !wrap ? row_q : ((row_q == '0) ? top_row_q : row_q - 1'b1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (in_ch.func == tgr_pkg::FUNC_HOME) begin
        col_d = line_start_q;
        row_d = top_row_q;
      end else begin
        col_d = wrap ? line_start_q : col_inc[tgr_pkg::COL_POS_W-1:0];
        row_d = row_adv;
        if (is_nl) begin
          col_d = line_start_q;
          row_d = (row_adv == '0) ? top_row_q : row_adv - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= tgr_pkg::LINE_START_RST;
      row_q <= tgr_pkg::TOP_ROW_RST;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  assign slot        = tgr_pkg::glyph_slot(in_ch.char_code);
  assign push_o      = accept && (in_ch.func != tgr_pkg::FUNC_HOME) && !is_nl;
  assign job_o.x     = col_q;
  assign job_o.y     = row_q;
  assign job_o.blank = !slot.hit;
  assign job_o.slot  = slot.slot;

endmodule

@@ src/tgr_queue.sv @@
module tgr_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tgr_pkg::job_t     job_i,
  input  logic              pop_i,
  output tgr_pkg::job_t     job_o,
  output tgr_pkg::q_stat_t  stat_o
);

  tgr_pkg::job_t                 entry_q [tgr_pkg::QUEUE_DEPTH];
  logic [tgr_pkg::QPTR_W-1:0]    wr_q, rd_q;
  logic [tgr_pkg::QCNT_W-1:0]    cnt_q;

  function automatic logic [tgr_pkg::QPTR_W-1:0] ptr_next(
    input logic [tgr_pkg::QPTR_W-1:0] p);
    logic [tgr_pkg::QPTR_W-1:0] r;
    r = (32'(p) == tgr_pkg::QUEUE_DEPTH - 1) ? '0 : p + 1'b1;
    return r;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= ptr_next(wr_q);
      end
      if (pop_i) begin
        rd_q <= ptr_next(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assign job_o        = entry_q[rd_q];
  assign stat_o.count = cnt_q;
  assign stat_o.full  = 32'(cnt_q) == tgr_pkg::QUEUE_DEPTH;
  assign stat_o.empty = cnt_q == '0;

endmodule

@@ src/tgr_back.sv @@
module tgr_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tgr_pkg::job_t     job_i,
  input  tgr_pkg::q_stat_t  q_stat_i,
  output logic              pop_o,
  tgr_out_if.source         out_ch
);

  tgr_pkg::job_t                 job_q;
  logic                          active_q;
  logic [tgr_pkg::BEAT_W-1:0]    beat_q, gbeat;
  logic                          out_valid_q, out_cmd_q, out_last_q;
  logic [tgr_pkg::BYTE_W-1:0]    out_byte_q;
  logic                          adv, last_beat, cmd;
  logic [tgr_pkg::BYTE_W-1:0]    byte_v, y2, colbyte, glyph_byte;
  logic [tgr_pkg::XPIX_W-1:0]    x12, x12e;
  logic [tgr_pkg::COL_W-1:0]     gcol;

  assign adv       = active_q && (!out_valid_q || out_ch.ready);
  assign last_beat = 32'(beat_q) == tgr_pkg::RUN_BEATS - 1;
  assign pop_o     = !q_stat_i.empty && (!active_q || (adv && last_beat));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      beat_q   <= '0;
    end else if (pop_o) begin
      active_q <= 1'b1;
      beat_q   <= '0;
    end else if (adv) begin
      active_q <= !last_beat;
      beat_q   <= beat_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
  end

  // 12x and 12x+10 as shifts, adds and a subtraction
  assign x12  = {2'b0, job_q.x, 2'b0} + {1'b0, job_q.x, 3'b0}
              - {2'b0, job_q.x, 2'b0} + {2'b0, job_q.x, 2'b0};
  assign x12e = x12 + tgr_pkg::X_END_OFFS;
  assign y2   = tgr_pkg::BYTE_W'({job_q.y, 1'b0});

  // glyph part: four bytes per column, high then low nibble, twice
  assign gbeat      = beat_q - tgr_pkg::BEAT_W'(tgr_pkg::HEADER_BEATS);
  assign gcol       = tgr_pkg::COL_W'(gbeat >> 2);
  assign colbyte    = job_q.blank ? tgr_pkg::BYTE_BLANK : tgr_pkg::FONT[job_q.slot][gcol];
  assign glyph_byte = gbeat[0] ? tgr_pkg::double_nibble(colbyte[3:0])
                               : tgr_pkg::double_nibble(colbyte[7:4]);

  always_comb begin
    cmd    = 1'b0;
    byte_v = glyph_byte;
    case (beat_q)
      6'd0:  begin cmd = 1'b1; byte_v = tgr_pkg::CMD_WIN_Y; end
      6'd1:  byte_v = y2;
      6'd2:  byte_v = y2 | 8'd1;
      6'd3:  begin cmd = 1'b1; byte_v = tgr_pkg::CMD_WIN_X; end
      6'd4:  byte_v = x12[7:0];
      6'd5:  byte_v = {7'b0, x12[8]};
      6'd6:  byte_v = x12e[7:0];
      6'd7:  byte_v = {7'b0, x12e[8]};
      6'd8:  begin cmd = 1'b1; byte_v = tgr_pkg::CMD_CNT_Y; end
      6'd9:  byte_v = y2;
      6'd10: begin cmd = 1'b1; byte_v = tgr_pkg::CMD_CNT_X; end
      6'd11: byte_v = x12[7:0];
      6'd12: byte_v = {7'b0, x12[8]};
      6'd13: begin cmd = 1'b1; byte_v = tgr_pkg::CMD_WRITE; end
      6'd14: byte_v = tgr_pkg::BYTE_BLANK;
      6'd15: byte_v = tgr_pkg::BYTE_BLANK;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_cmd_q  <= cmd;
      out_byte_q <= byte_v;
      out_last_q <= last_beat;
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.is_command = out_cmd_q;
  assign out_ch.byte_value = out_byte_q;
  assign out_ch.last       = out_last_q;

endmodule

@@ src/text_glyph_renderer_2x.sv @@
// draw item: 36 beats, one per cycle when the sink keeps ready high; an item goes
// through queue entry, job register, then output register to give its first beat
// the single-byte output sequencer handles one draw item at a time
// home and newline items only move the cursor and give no beats
// reset: asynchronous active low; cursor to column 7 row 7, line start 7, line end 19,
// top row 7; queue and output emptied
module text_glyph_renderer_2x (
  input  logic       clk_i,
  input  logic       rst_ni,
  tgr_in_if.sink     in_ch,
  tgr_cfg_if.sink    cfg_ch,
  tgr_out_if.source  out_ch
);

  // front to queue
  logic              push;
  tgr_pkg::job_t     push_job;

  // queue to back
  logic              pop;
  tgr_pkg::job_t     head_job;
  tgr_pkg::q_stat_t  q_stat;

  // front: config registers, cursor update, glyph lookup; stalls only on a full queue
  tgr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .q_stat_i (q_stat),
    .push_o   (push),
    .job_o    (push_job)
  );

  // short job queue so the front keeps taking items while a run drains
  tgr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .stat_o (q_stat)
  );

  // back: beat sequencer and output register, next job loaded on the last beat
  tgr_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .job_i    (head_job),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .out_ch   (out_ch)
  );

`ifndef SYNTHESIS
  // queue never overfills
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(q_stat.count) <= tgr_pkg::QUEUE_DEPTH)
    else $error("job queue overflow");

  // no pop from an empty queue and no push into a full one
  a_queue_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop && q_stat.empty) && !(push && q_stat.full))
    else $error("job queue misuse");

  // output only goes valid at the start of a run
  a_run_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_ch.valid) |-> out_ch.is_command && out_ch.byte_value == tgr_pkg::CMD_WIN_Y)
    else $error("run started mid sequence");

  // the closing beat of a run is glyph data
  a_last_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.last |-> !out_ch.is_command)
    else $error("last flag on a command beat");
`endif

endmodule

@@ test/text_glyph_renderer_2x_test.sv @@
module text_glyph_renderer_2x_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tgr_pkg::*;

  // cycles to let pass after the last byte so queued home/newline items settle
  localparam int SETTLE_CYCLES = 8;

  // draw item versus home item on the func field
  localparam logic FUNC_DRAW = ~FUNC_HOME;

  // byte kinds on the panel bus
  localparam logic IS_CMD  = 1'b1;
  localparam logic IS_DATA = 1'b0;

  // register index past the end of the list, must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  // one beat on the panel output
  typedef struct packed {
    logic              is_cmd;
    logic [BYTE_W-1:0] value;
    logic              last;
  } panel_byte_t;

  // cursor and layout tracking, plus the bytes each draw must produce
  class glyph_run_model;
    logic [COL_POS_W-1:0] start_col;
    logic [COL_POS_W-1:0] end_col;
    logic [ROW_POS_W-1:0] top;
    logic [COL_POS_W-1:0] cur_col;
    logic [ROW_POS_W-1:0] cur_row;
    panel_byte_t          bytes_due[$];
    int unsigned          mismatches;

    function new();
      start_col  = LINE_START_RST;
      end_col    = LINE_END_RST;
      top        = TOP_ROW_RST;
      cur_col    = LINE_START_RST;
      cur_row    = TOP_ROW_RST;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LINE_START: start_col = data;
        CFG_LINE_END:   end_col   = data;
        CFG_TOP_ROW:    top       = data[ROW_POS_W-1:0];
        default: ;
      endcase
    endfunction

    // rows count down, row zero wraps straight back to the top
    function void row_down();
      if (cur_row == '0) cur_row = top;
      else cur_row = cur_row - 1'b1;
    endfunction

    function int font_slot(logic [CHAR_W-1:0] ch);
      int code;
      int s;
      code = int'(ch);
      s    = -1;
      if (code >= 65 && code <= 90) s = code - 65;
      else if (code >= 97 && code <= 122) s = code - 97 + 26;
      else if (code >= 48 && code <= 57) s = code - 48 + 52;
      else if (code == 58) s = 62;
      else if (code == 32) s = 63;
      if (s >= GLYPH_COUNT) s = -1;
      return s;
    endfunction

    function logic [BYTE_W-1:0] widen(logic [3:0] n);
      return {{2{n[3]}}, {2{n[2]}}, {2{n[1]}}, {2{n[0]}}};
    endfunction

    function void due(logic c, logic [BYTE_W-1:0] v, logic l);
      bytes_due.push_back('{c, v, l});
    endfunction

    function void take_item(logic f, logic [CHAR_W-1:0] ch);
      logic [COL_POS_W-1:0] x;
      logic [ROW_POS_W-1:0] y;
      logic [COL_POS_W:0]   nxt;
      logic [XPIX_W-1:0]    x12;
      logic [XPIX_W-1:0]    x12e;
      logic [BYTE_W-1:0]    bits;
      logic [BYTE_W-1:0]    hi;
      logic [BYTE_W-1:0]    lo;
      int                   s;
      if (f == FUNC_HOME) begin
        cur_col = start_col;
        cur_row = top;
        return;
      end
      x   = cur_col;
      y   = cur_row;
      nxt = {1'b0, cur_col} + 1'b1;
      if (nxt > {1'b0, end_col}) begin
        cur_col = start_col;
        row_down();
      end else begin
        cur_col = nxt[COL_POS_W-1:0];
      end
      if (ch == CH_NEWLINE) begin
        cur_col = start_col;
        row_down();
        return;
      end
      x12  = {4'b0, x} * 9'd12;
      x12e = x12 + X_END_OFFS;
      due(IS_CMD,  CMD_WIN_Y, 1'b0);
      due(IS_DATA, {3'b0, y, 1'b0}, 1'b0);
      due(IS_DATA, {3'b0, y, 1'b1}, 1'b0);
      due(IS_CMD,  CMD_WIN_X, 1'b0);
      due(IS_DATA, x12[7:0], 1'b0);
      due(IS_DATA, 8'(x12 >> 8), 1'b0);
      due(IS_DATA, x12e[7:0], 1'b0);
      due(IS_DATA, 8'(x12e >> 8), 1'b0);
      due(IS_CMD,  CMD_CNT_Y, 1'b0);
      due(IS_DATA, {3'b0, y, 1'b0}, 1'b0);
      due(IS_CMD,  CMD_CNT_X, 1'b0);
      due(IS_DATA, x12[7:0], 1'b0);
      due(IS_DATA, 8'(x12 >> 8), 1'b0);
      due(IS_CMD,  CMD_WRITE, 1'b0);
      due(IS_DATA, BYTE_BLANK, 1'b0);
      due(IS_DATA, BYTE_BLANK, 1'b0);
      s = font_slot(ch);
      for (int c = 0; c < GLYPH_COLUMNS; c++) begin
        bits = (s >= 0) ? FONT[s][c] : BYTE_BLANK;
        hi   = widen(bits[7:4]);
        lo   = widen(bits[3:0]);
        due(IS_DATA, hi, 1'b0);
        due(IS_DATA, lo, 1'b0);
        due(IS_DATA, hi, 1'b0);
        due(IS_DATA, lo, c == GLYPH_COLUMNS - 1);
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    function void check_byte(logic c, logic [BYTE_W-1:0] v, logic l);
      panel_byte_t want;
      if (bytes_due.size() == 0) begin
        flag($sformatf("unexpected beat cmd=%0b byte=%02h last=%0b", c, v, l));
        return;
      end
      want = bytes_due.pop_front();
      if (want.is_cmd !== c || want.value !== v || want.last !== l) begin
        flag($sformatf("expected cmd=%0b byte=%02h last=%0b, got cmd=%0b byte=%02h last=%0b",
                       want.is_cmd, want.value, want.last, c, v, l));
      end
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // when set, neither side inserts gaps
  bit calm = 1'b0;

  glyph_run_model runs = new();

  tgr_in_if  in_ch();
  tgr_cfg_if cfg_ch();
  tgr_out_if out_ch();

  text_glyph_renderer_2x DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  always #2 clk_i = ~clk_i;

  // panel side: check each accepted beat, then pick ready for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      runs.check_byte(out_ch.is_command, out_ch.byte_value, out_ch.last);
    end
    out_ch.ready <= calm || ($urandom_range(99) >= 20);
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("text_glyph_renderer_2x_test failed");
    $finish;
  end

  // one character beat; valid is left high so back-to-back items need no drop
  task automatic send_item(input logic f, input logic [CHAR_W-1:0] ch);
    if (!calm && $urandom_range(99) < 20) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 50);
    end
    in_ch.valid     <= 1'b1;
    in_ch.func      <= f;
    in_ch.char_code <= ch;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    runs.take_item(f, ch);
  endtask

  task automatic draw(input logic [CHAR_W-1:0] ch);
    send_item(FUNC_DRAW, ch);
  endtask

  // register beat; the caller drops valid after the last one
  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    runs.write_reg(idx, val);
  endtask

  // stop sending, wait for every due byte, then let in-flight items settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (runs.bytes_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // new line layout, written only once the block is idle
  task automatic set_layout(input logic [4:0] s, input logic [4:0] e, input logic [4:0] t,
                            input bit spare);
    drain();
    write_cfg(CFG_LINE_START, s);
    write_cfg(CFG_LINE_END, e);
    write_cfg(CFG_TOP_ROW, t);
    if (spare) write_cfg(CFG_SPARE, 5'($urandom_range(31)));
    cfg_ch.valid <= 1'b0;
  endtask

  // column or row register value, biased toward the ends of the range
  function automatic logic [4:0] pick_reg(input logic [4:0] hi);
    case ($urandom_range(3))
      0: return 5'd0;
      1: return hi;
      default: return 5'($urandom_range(31));
    endcase
  endfunction

  // mostly printable glyphs, some codes with no glyph, some newlines
  function automatic logic [CHAR_W-1:0] pick_char();
    case ($urandom_range(9))
      0, 1: return 8'(65 + $urandom_range(25));
      2, 3: return 8'(97 + $urandom_range(25));
      4, 5: return 8'(48 + $urandom_range(9));
      6:    return ($urandom_range(1) == 0) ? 8'd58 : 8'd32;
      7:    return CH_NEWLINE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int roll;
    in_ch.valid     <= 1'b0;
    in_ch.func      <= FUNC_DRAW;
    in_ch.char_code <= '0;
    cfg_ch.valid    <= 1'b0;
    cfg_ch.index    <= CFG_LINE_START;
    cfg_ch.data     <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset layout: glyph classes, codes with no glyph, newline, home
    draw(8'h41);
    draw(8'h5A);
    draw(8'h61);
    draw(8'h7A);
    draw(8'h30);
    draw(8'h39);
    draw(8'h3A);
    draw(8'h20);
    draw(8'h00);
    draw(8'h7F);
    draw(8'h80);
    draw(8'hFF);
    draw(CH_NEWLINE);
    send_item(FUNC_HOME, 8'hFF);
    draw(8'h4D);

    // rightmost column and bottom-most top row, x crosses the 256 pixel line
    set_layout(5'd31, 5'd31, 5'd15, 1'b1);
    send_item(FUNC_HOME, 8'h00);
    draw(8'h42);
    draw(8'h43);
    draw(CH_NEWLINE);

    // start past end and top at row zero, so every step wraps at once
    set_layout(5'd20, 5'd5, 5'd0, 1'b0);
    send_item(FUNC_HOME, CH_NEWLINE);
    draw(8'h71);
    draw(CH_NEWLINE);
    draw(8'h35);

    // random layouts, the third phase runs with no gaps on either side
    for (int phase = 0; phase < 6; phase++) begin
      set_layout(pick_reg(5'd31), pick_reg(5'd31), pick_reg(5'd15), $urandom_range(3) == 0);
      calm = (phase == 2);
      if ($urandom_range(1) == 0) send_item(FUNC_HOME, 8'($urandom_range(255)));
      for (int n = 0; n < 26; n++) begin
        roll = $urandom_range(99);
        if (roll < 5) send_item(FUNC_HOME, 8'($urandom_range(255)));
        else draw(pick_char());
      end
      calm = 1'b0;
    end

    drain();
    if (runs.mismatches == 0) begin
      $display("text_glyph_renderer_2x_test passed");
    end else begin
      $display("text_glyph_renderer_2x_test failed");
    end
    $finish;
  end

endmodule
